>>> rtl/vfc_pkg.sv
package vfc_pkg;

   // Grid storage and field widths.
   localparam int MAX_DIM   = 32;
   localparam int POS_W     = 5;
   localparam int DIM_W     = 6;
   localparam int VIDX_W    = 20;
   localparam int FACE_W    = 3;
   localparam int PAT_W     = 3;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam int CRD_W     = $clog2(MAX_DIM);
   localparam int ROW_AW    = 2 * CRD_W;
   localparam int ROWS      = 2 ** ROW_AW;
   localparam int EDIM_W    = $clog2(MAX_DIM + 1);
   // The shared multiplier also scales by the vertex count per voxel.
   localparam int MULB_W    = (EDIM_W > 5) ? EDIM_W : 5;

   localparam int NUM_FACES       = 6;
   localparam int VERTS_PER_FACE  = 6;
   localparam int VERTS_PER_BLOCK = 24;

   localparam int FACE_FRONT  = 0;
   localparam int FACE_BACK   = 1;
   localparam int FACE_LEFT   = 2;
   localparam int FACE_RIGHT  = 3;
   localparam int FACE_TOP    = 4;
   localparam int FACE_BOTTOM = 5;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type STEP_CLR  = 4'd0;
   localparam pc_type STEP_IDLE = 4'd1;
   localparam pc_type STEP_CHK  = 4'd2;
   localparam pc_type STEP_DISP = 4'd3;
   localparam pc_type STEP_NBX0 = 4'd4;
   localparam pc_type STEP_NBX1 = 4'd5;
   localparam pc_type STEP_NBY0 = 4'd6;
   localparam pc_type STEP_NBY1 = 4'd7;
   localparam pc_type STEP_EMIT = 4'd8;
   localparam pc_type STEP_WR   = 4'd9;

   typedef enum logic [2:0] {
      RS_NONE, RS_SELF, RS_XM, RS_XP, RS_YP, RS_YM
   } rsel_type;

   typedef enum logic [1:0] {
      ALU_NOP, ALU_XH, ALU_DZ, ALU_M24
   } alu_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_SELF, CAP_LEFT, CAP_RIGHT, CAP_TOP, CAP_BOTTOM
   } cap_type;

   typedef enum logic [2:0] {
      CND_NEVER, CND_ALWAYS, CND_ACCEPT, CND_BAD, CND_WRITE, CND_EMPTY,
      CND_CLR_LAST, CND_EMIT_DONE
   } cond_type;

   typedef struct packed {
      logic     ready;
      logic     clr;
      logic     wr;
      logic     emit_init;
      logic     emit;
      rsel_type rsel;
      alu_type  alu;
      cap_type  cap;
      cond_type cond;
      logic     hold;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic bad;
      logic is_write;
      logic empty;
      logic clr_last;
      logic emit_done;
   } stat_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] depth;
   } dims_type;

   // Control store. A taken condition jumps to target; otherwise a hold
   // step repeats and any other step falls through to the next one.
   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type c;
      c = '0;
      case (pc)
         STEP_CLR: begin
            c.clr = 1'b1;
            c.cond = CND_CLR_LAST;
            c.target = STEP_IDLE;
            c.hold = 1'b1;
         end
         STEP_IDLE: begin
            c.ready = 1'b1;
            c.cond = CND_ACCEPT;
            c.target = STEP_CHK;
            c.hold = 1'b1;
         end
         STEP_CHK: begin
            c.rsel = RS_SELF;
            c.alu = ALU_XH;
            c.cond = CND_BAD;
            c.target = STEP_IDLE;
         end
         STEP_DISP: begin
            c.rsel = RS_XM;
            c.alu = ALU_DZ;
            c.cap = CAP_SELF;
            c.cond = CND_WRITE;
            c.target = STEP_WR;
         end
         STEP_NBX0: begin
            c.rsel = RS_XP;
            c.alu = ALU_M24;
            c.cap = CAP_LEFT;
            c.cond = CND_EMPTY;
            c.target = STEP_IDLE;
         end
         STEP_NBX1: begin
            c.rsel = RS_YP;
            c.cap = CAP_RIGHT;
         end
         STEP_NBY0: begin
            c.rsel = RS_YM;
            c.cap = CAP_TOP;
         end
         STEP_NBY1: begin
            c.cap = CAP_BOTTOM;
            c.emit_init = 1'b1;
         end
         STEP_EMIT: begin
            c.emit = 1'b1;
            c.cond = CND_EMIT_DONE;
            c.target = STEP_IDLE;
            c.hold = 1'b1;
         end
         STEP_WR: begin
            c.wr = 1'b1;
            c.cond = CND_ALWAYS;
            c.target = STEP_IDLE;
         end
         default: begin
            c.cond = CND_ALWAYS;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

   // Vertex offsets of the two triangles of one face.
   function automatic logic [1:0] tri_pattern(input logic [PAT_W-1:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd2;
         3'd3:    r = 2'd0;
         3'd4:    r = 2'd2;
         3'd5:    r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // A zero extent counts as one, anything above the grid as the grid size.
   function automatic logic [EDIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [EDIM_W-1:0] r;
      if (v == '0) begin
         r = EDIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = EDIM_W'(MAX_DIM);
      end else begin
         r = EDIM_W'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/vfc_csr.sv
module vfc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [vfc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [vfc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [vfc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output vfc_pkg::dims_type             dims
);
   import vfc_pkg::*;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DEPTH  = 2'd2;

   dims_type   dims_ff, dims_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[CSR_AW-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign dims = dims_ff;

   always_comb begin
      dims_in = dims_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WIDTH:  dims_in.width  = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: dims_in.height = csr_pwdata[DIM_W-1:0];
            REG_DEPTH:  dims_in.depth  = csr_pwdata[DIM_W-1:0];
            default:    dims_in = dims_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(dims_ff.width);
         REG_HEIGHT: csr_prdata = CSR_DW'(dims_ff.height);
         REG_DEPTH:  csr_prdata = CSR_DW'(dims_ff.depth);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.width  <= DIM_W'(MAX_DIM);
         dims_ff.height <= DIM_W'(MAX_DIM);
         dims_ff.depth  <= DIM_W'(MAX_DIM);
      end else begin
         dims_ff <= dims_in;
      end
   end

endmodule

>>> rtl/vfc_seq.sv
module vfc_seq (
   input  logic              clock,
   input  logic              reset,
   input  vfc_pkg::stat_type stat,
   output vfc_pkg::ctrl_type ctrl
);
   import vfc_pkg::*;

   pc_type pc_ff, pc_in;
   logic   take;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         CND_NEVER:     take = 1'b0;
         CND_ALWAYS:    take = 1'b1;
         CND_ACCEPT:    take = stat.accept;
         CND_BAD:       take = stat.bad;
         CND_WRITE:     take = stat.is_write;
         CND_EMPTY:     take = stat.empty;
         CND_CLR_LAST:  take = stat.clr_last;
         CND_EMIT_DONE: take = stat.emit_done;
         default:       take = 1'b0;
      endcase
      if (take) begin
         pc_in = ctrl.target;
      end else if (ctrl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> rtl/vfc_dpath.sv
module vfc_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  vfc_pkg::ctrl_type             ctrl,
   output vfc_pkg::stat_type             stat,
   input  vfc_pkg::dims_type             dims,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_x,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_y,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_z,
   input  logic                          req_occupied,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vfc_pkg::VIDX_W-1:0]    rsp_vertex_index,
   output logic [vfc_pkg::FACE_W-1:0]    rsp_face_code,
   output logic                          rsp_last
);
   import vfc_pkg::*;

   // Occupancy bitmap: one row per (x, y), one bit per z.
   logic [MAX_DIM-1:0] occ_mem [ROWS];

   logic               type_ff;
   logic [POS_W-1:0]   x_ff, y_ff, z_ff;
   logic               occ_wr_ff;
   logic               accept;

   logic [EDIM_W-1:0]  w, h, d;
   logic [CRD_W-1:0]   xc, yc, zc, xm, xp, ym, yp, zm, zp;

   logic               rd_en, we;
   logic [ROW_AW-1:0]  rd_addr, wr_addr;
   logic [MAX_DIM-1:0] wr_data, rd_data_ff, row_ff, bit_sel;
   logic [ROW_AW-1:0]  clr_cnt_ff;

   logic               occ_self_ff;
   logic [NUM_FACES-1:0] vis_ff;
   logic               nb_occ;

   logic [VIDX_W-1:0]  mul_a, mul_add, acc_ff, acc_in;
   logic [MULB_W-1:0]  mul_b;
   logic [VIDX_W+MULB_W-1:0] prod;

   logic [FACE_W-1:0]  face_ff;
   logic [PAT_W-1:0]   pat_ff;
   logic               emit_done, cur_vis, slot_free, load, advance;
   logic [NUM_FACES-1:0] upto_mask;
   logic [VIDX_W-1:0]  vertex_in;
   logic               last_in;

   logic               rsp_valid_ff;
   logic [VIDX_W-1:0]  rsp_vertex_ff;
   logic [FACE_W-1:0]  rsp_face_ff;
   logic               rsp_last_ff;

   // ---------------- request capture ----------------
   assign req_ready = ctrl.ready;
   assign accept = req_valid & ctrl.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
         z_ff      <= req_pos_z;
         occ_wr_ff <= req_occupied;
      end
   end

   assign w = eff_dim(dims.width);
   assign h = eff_dim(dims.height);
   assign d = eff_dim(dims.depth);

   assign xc = CRD_W'(x_ff);
   assign yc = CRD_W'(y_ff);
   assign zc = CRD_W'(z_ff);
   assign xm = xc - 1'b1;
   assign xp = xc + 1'b1;
   assign ym = yc - 1'b1;
   assign yp = yc + 1'b1;
   assign zm = zc - 1'b1;
   assign zp = zc + 1'b1;

   // ---------------- occupancy memory ----------------
   always_comb begin
      case (ctrl.rsel)
         RS_SELF: rd_addr = {xc, yc};
         RS_XM:   rd_addr = {xm, yc};
         RS_XP:   rd_addr = {xp, yc};
         RS_YP:   rd_addr = {xc, yp};
         RS_YM:   rd_addr = {xc, ym};
         default: rd_addr = {xc, yc};
      endcase
   end

   assign rd_en = (ctrl.rsel != RS_NONE);
   assign bit_sel = MAX_DIM'(1) << zc;
   assign we = ctrl.clr | ctrl.wr;
   assign wr_addr = ctrl.clr ? clr_cnt_ff : {xc, yc};
   assign wr_data = ctrl.clr ? '0 :
                    (occ_wr_ff ? (row_ff | bit_sel) : (row_ff & ~bit_sel));

   always_ff @(posedge clock) begin
      if (we) begin
         occ_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= occ_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctrl.clr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // ---------------- neighbor captures ----------------
   assign nb_occ = rd_data_ff[zc];

   always_ff @(posedge clock) begin
      case (ctrl.cap)
         CAP_SELF: begin
            row_ff      <= rd_data_ff;
            occ_self_ff <= rd_data_ff[zc];
            vis_ff[FACE_FRONT] <= (int'(z_ff) + 1 >= int'(d)) || !rd_data_ff[zp];
            vis_ff[FACE_BACK]  <= (z_ff == '0) || !rd_data_ff[zm];
         end
         CAP_LEFT:   vis_ff[FACE_LEFT]   <= (x_ff == '0) || !nb_occ;
         CAP_RIGHT:  vis_ff[FACE_RIGHT]  <= (int'(x_ff) + 1 >= int'(w)) || !nb_occ;
         CAP_TOP:    vis_ff[FACE_TOP]    <= (int'(y_ff) + 1 >= int'(h)) || !nb_occ;
         CAP_BOTTOM: vis_ff[FACE_BOTTOM] <= (y_ff == '0) || !nb_occ;
         default:    vis_ff <= vis_ff;
      endcase
   end

   // ---------------- linear index multiplier ----------------
   always_comb begin
      case (ctrl.alu)
         ALU_XH: begin
            mul_a   = VIDX_W'(x_ff);
            mul_b   = MULB_W'(h);
            mul_add = VIDX_W'(y_ff);
         end
         ALU_DZ: begin
            mul_a   = acc_ff;
            mul_b   = MULB_W'(d);
            mul_add = VIDX_W'(z_ff);
         end
         ALU_M24: begin
            mul_a   = acc_ff;
            mul_b   = MULB_W'(VERTS_PER_BLOCK);
            mul_add = '0;
         end
         default: begin
            mul_a   = acc_ff;
            mul_b   = MULB_W'(1);
            mul_add = '0;
         end
      endcase
      prod   = (VIDX_W + MULB_W)'(mul_a) * (VIDX_W + MULB_W)'(mul_b);
      acc_in = prod[VIDX_W-1:0] + mul_add;
   end

   always_ff @(posedge clock) begin
      if (ctrl.alu != ALU_NOP) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------- result emitter ----------------
   assign emit_done = (face_ff == FACE_W'(NUM_FACES));
   assign cur_vis   = !emit_done && vis_ff[face_ff];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load      = ctrl.emit && cur_vis && slot_free;
   // A hidden face is skipped without waiting for the output slot.
   assign advance   = ctrl.emit && !emit_done && (!cur_vis || slot_free);

   assign upto_mask = (NUM_FACES'(2) << face_ff) - 1'b1;
   assign last_in   = (pat_ff == PAT_W'(VERTS_PER_FACE - 1)) &&
                      ((vis_ff & ~upto_mask) == '0);
   assign vertex_in = acc_ff + VIDX_W'({face_ff, 2'b00}) + VIDX_W'(tri_pattern(pat_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         face_ff <= FACE_W'(NUM_FACES);
         pat_ff  <= '0;
      end else if (ctrl.emit_init) begin
         face_ff <= '0;
         pat_ff  <= '0;
      end else if (advance) begin
         if (!cur_vis || pat_ff == PAT_W'(VERTS_PER_FACE - 1)) begin
            face_ff <= face_ff + 1'b1;
            pat_ff  <= '0;
         end else begin
            pat_ff <= pat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_vertex_ff <= vertex_in;
         rsp_face_ff   <= face_ff;
         rsp_last_ff   <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vertex_ff;
   assign rsp_face_code    = rsp_face_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------- status to sequencer ----------------
   assign stat.accept    = accept;
   assign stat.bad       = (int'(x_ff) >= int'(w)) || (int'(y_ff) >= int'(h)) ||
                           (int'(z_ff) >= int'(d));
   assign stat.is_write  = (type_ff == REQ_WRITE);
   assign stat.empty     = !occ_self_ff;
   assign stat.clr_last  = (clr_cnt_ff == '1);
   assign stat.emit_done = emit_done;

`ifndef ASSERT_OFF
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_face_ff) < NUM_FACES))
      else $error("face code out of range");

   a_last_pattern: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_vertex_ff[1:0] == 2'b11))
      else $error("last item does not close a face");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> emit_done)
      else $error("new item accepted while emitter busy");

   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      $fell(ctrl.clr) |-> $past(clr_cnt_ff == '1))
      else $error("clearing pass ended early");
`endif

endmodule

>>> rtl/voxel_face_cull_index_gen.sv
// Channel  Direction  Signals                                     Moves
// req      in         req_valid/ready, req_type, req_pos_x/y/z,    one write or query item
//                     req_occupied
// rsp      out        rsp_valid/ready, rsp_vertex_index,           one vertex index item
//                     rsp_face_code, rsp_last
// csr      in/out     csr_psel/penable/pwrite/paddr/pwdata,        grid extent registers
//                     csr_prdata, csr_pready
//
// A write item reads its row and writes it back with one bit changed before ready returns.
// A query reads its own row and four neighbor rows, then emits the indices of each visible
// face, skips each hidden face and takes a closing step before ready returns. Out-of-range
// items return to ready after the range check, empty voxels after their own row is read.
// After reset the memory is swept clear, one row per cycle, through all 1024 rows with
// req_ready low. A stalled rsp holds the output register; hidden faces still get skipped.
module voxel_face_cull_index_gen (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_x,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_y,
   input  logic [vfc_pkg::POS_W-1:0]     req_pos_z,
   input  logic                          req_occupied,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vfc_pkg::VIDX_W-1:0]    rsp_vertex_index,
   output logic [vfc_pkg::FACE_W-1:0]    rsp_face_code,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [vfc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [vfc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [vfc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import vfc_pkg::*;

   dims_type dims;
   ctrl_type ctrl;
   stat_type stat;

   vfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   vfc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   vfc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .dims             (dims),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_occupied     (req_occupied),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_face_code    (rsp_face_code),
      .rsp_last         (rsp_last)
   );

endmodule
